@@ rtl/rdm_disc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdm_disc_pkg
// Types and constants for the discovery response decoder.
// ----------------------------------------------------------------------------
package rdm_disc_pkg;

  // Frame format constants.
  localparam logic [7:0]  SEP_BYTE   = 8'hAA;
  localparam logic [3:0]  MARK_NIB   = 4'hF;
  localparam logic [15:0] SUM_BIAS   = 16'h00FF;
  localparam logic [3:0]  BODY_LEN   = 4'd14;
  localparam logic [3:0]  PAIR_BYTES = 4'd12;
  localparam logic [2:0]  MIN_LEN    = 3'd4;
  localparam logic [2:0]  MIN_LEAD   = 3'd2;

  localparam int UID_W = 48;

  // Outcome of one frame.
  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_SINGLE    = 2'd1,
    ST_COLLISION = 2'd2
  } status_t;

  // Result of one frame as handed from the parser to the output register.
  typedef struct packed {
    status_t            status;
    logic [UID_W-1:0]   device_uid;
  } result_t;

endpackage

@@ rtl/rdm_disc_in_if.sv @@
// ----------------------------------------------------------------------------
// rdm_disc_in_if
// Byte channel into the decoder: one frame byte per transfer.
// ----------------------------------------------------------------------------
interface rdm_disc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

@@ rtl/rdm_disc_out_if.sv @@
// ----------------------------------------------------------------------------
// rdm_disc_out_if
// Result channel out of the decoder: one frame outcome per transfer.
// ----------------------------------------------------------------------------
interface rdm_disc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] device_uid;

  modport source (output valid, output status, output device_uid, input ready);
  modport sink   (input valid, input status, input device_uid, output ready);
endinterface

@@ rtl/rdm_disc_parse.sv @@
// ----------------------------------------------------------------------------
// rdm_disc_parse
// Running frame state: separator search, nibble pair decode and checksum.
// ----------------------------------------------------------------------------
module rdm_disc_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_end,
  output rdm_disc_pkg::result_t result
);

  logic [2:0]  bytes_seen_r,  bytes_seen_nxt;
  logic        sep_seen_r,    sep_seen_nxt;
  logic        sep_early_r,   sep_early_nxt;
  logic [3:0]  body_idx_r,    body_idx_nxt;
  logic        nib_fault_r,   nib_fault_nxt;
  logic [47:0] uid_r,         uid_nxt;
  logic [15:0] sum_r,         sum_nxt;
  logic [15:0] rx_sum_r,      rx_sum_nxt;

  // Next state for one byte.
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    sep_seen_nxt   = sep_seen_r;
    sep_early_nxt  = sep_early_r;
    body_idx_nxt   = body_idx_r;
    nib_fault_nxt  = nib_fault_r;
    uid_nxt        = uid_r;
    sum_nxt        = sum_r;
    rx_sum_nxt     = rx_sum_r;

    if (!sep_seen_r) begin
      if (rx_byte == rdm_disc_pkg::SEP_BYTE) begin
        sep_seen_nxt  = 1'b1;
        sep_early_nxt = (bytes_seen_r < rdm_disc_pkg::MIN_LEAD);
      end
    end else if (body_idx_r < rdm_disc_pkg::BODY_LEN) begin
      if (body_idx_r < rdm_disc_pkg::PAIR_BYTES) begin
        if (rx_byte[7:4] != rdm_disc_pkg::MARK_NIB) begin
          nib_fault_nxt = 1'b1;
        end
        uid_nxt = {uid_r[43:0], rx_byte[3:0]};
        // The low byte of each pair completes one decoded byte.
        if (body_idx_r[0]) begin
          sum_nxt = sum_r + {8'h00, uid_r[3:0], rx_byte[3:0]} + rdm_disc_pkg::SUM_BIAS;
        end
      end else begin
        rx_sum_nxt = {rx_sum_r[7:0], rx_byte};
      end
      body_idx_nxt = body_idx_r + 4'd1;
    end

    if (bytes_seen_r < rdm_disc_pkg::MIN_LEN) begin
      bytes_seen_nxt = bytes_seen_r + 3'd1;
    end
  end

  // Frame outcome from the state including this byte.
  always_comb begin
    result.status     = rdm_disc_pkg::ST_SINGLE;
    result.device_uid = uid_nxt;
    if (bytes_seen_nxt < rdm_disc_pkg::MIN_LEN) begin
      result.status     = rdm_disc_pkg::ST_EMPTY;
      result.device_uid = '0;
    end else if (!sep_seen_nxt || sep_early_nxt ||
                 (body_idx_nxt < rdm_disc_pkg::BODY_LEN) || nib_fault_nxt ||
                 (sum_nxt != rx_sum_nxt)) begin
      result.status     = rdm_disc_pkg::ST_COLLISION;
      result.device_uid = '0;
    end
  end

  // State register; the last byte of a frame returns it to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      bytes_seen_r <= '0;
      sep_seen_r   <= 1'b0;
      sep_early_r  <= 1'b0;
      body_idx_r   <= '0;
      nib_fault_r  <= 1'b0;
      uid_r        <= '0;
      sum_r        <= '0;
      rx_sum_r     <= '0;
    end else if (step) begin
      bytes_seen_r <= bytes_seen_nxt;
      sep_seen_r   <= sep_seen_nxt;
      sep_early_r  <= sep_early_nxt;
      body_idx_r   <= body_idx_nxt;
      nib_fault_r  <= nib_fault_nxt;
      uid_r        <= uid_nxt;
      sum_r        <= sum_nxt;
      rx_sum_r     <= rx_sum_nxt;
    end
  end

endmodule

@@ rtl/rdm_discovery_response_decoder_core.sv @@
// ----------------------------------------------------------------------------
// rdm_discovery_response_decoder_core
// Decodes one received discovery response frame into empty, single or collision.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on in_ch, one byte per transfer, with frame_end set
// on the last byte. Bytes before the first separator, the nibble pairs, the
// checksum and any trailing bytes all flow through the same channel. One
// result per frame leaves on out_ch: status and, for a single device, the UID
// with the first wire byte most significant; the UID reads zero otherwise.
// Throughput is one byte per cycle unless a frame's last byte waits for the
// result register; the running state updates in a single pass from the input
// register. The result appears on out_ch once the frame's last byte moves
// from the input register into the result register.
// If the receiver stalls, the result register holds; bytes that do not end a
// frame keep flowing, and a frame's last byte waits in the input register
// until the result register is free, which then holds off in_ch.
// Reset (rst_n low, synchronous) clears the valid bits of both registers and the frame state.
// ----------------------------------------------------------------------------
module rdm_discovery_response_decoder_core (
  input  logic           clk,
  input  logic           rst_n,
  rdm_disc_in_if.sink    in_ch,
  rdm_disc_out_if.source out_ch
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_end_r;
  logic                  out_valid_r;
  rdm_disc_pkg::result_t out_res_r;
  rdm_disc_pkg::result_t res;
  logic                  out_free;
  logic                  step;

  // A byte advances unless it ends a frame and the result register is busy.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && (!in_end_r || out_free);
  assign in_ch.ready = !in_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
      in_end_r  <= in_ch.frame_end;
    end
  end

  rdm_disc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .frame_end (in_end_r),
    .result    (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_end_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.device_uid = out_res_r.device_uid;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the discovery response decoder. Frames are driven
// one byte per transfer with random gaps. They include well-formed responses
// with random UIDs, corrupted ones, truncated ones and plain noise. A
// scoreboard tracks the frame state byte by byte and predicts one outcome per
// frame. It compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // Shapes of frames produced by the random generator.
  typedef enum int {
    FK_GOOD,
    FK_BAD_NIBBLE,
    FK_BAD_SUM,
    FK_EARLY_SEP,
    FK_CUT_BODY,
    FK_NO_SEP,
    FK_SHORT,
    FK_NOISE
  } frame_kind_t;

  localparam int BYTE_TARGET = 1550;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED = 30;

  // Tracks the decoder's frame state and keeps the outcomes still owed.
  class disc_frame_scoreboard;
    logic [2:0]  n_bytes;
    bit          sep_found;
    bit          sep_early;
    logic [3:0]  body_cnt;
    bit          nib_bad;
    logic [47:0] uid_acc;
    logic [15:0] sum_acc;
    logic [15:0] rx_sum;
    rdm_disc_pkg::result_t outcome_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      n_bytes   = '0;
      sep_found = 1'b0;
      sep_early = 1'b0;
      body_cnt  = '0;
      nib_bad   = 1'b0;
      uid_acc   = '0;
      sum_acc   = '0;
      rx_sum    = '0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Called for every byte transfer accepted on the input channel.
    function void note_byte(logic [7:0] b, logic last);
      rdm_disc_pkg::result_t r;
      if (!sep_found) begin
        if (b == rdm_disc_pkg::SEP_BYTE) begin
          sep_found = 1'b1;
          sep_early = (n_bytes < rdm_disc_pkg::MIN_LEAD);
        end
      end else if (body_cnt < rdm_disc_pkg::BODY_LEN) begin
        if (body_cnt < rdm_disc_pkg::PAIR_BYTES) begin
          if (b[7:4] != rdm_disc_pkg::MARK_NIB) nib_bad = 1'b1;
          uid_acc = {uid_acc[43:0], b[3:0]};
          // A full byte is assembled after every low nibble.
          if (body_cnt[0])
            sum_acc = sum_acc + {8'h00, uid_acc[7:0]} + rdm_disc_pkg::SUM_BIAS;
        end else begin
          rx_sum = {rx_sum[7:0], b};
        end
        body_cnt++;
      end
      if (n_bytes < rdm_disc_pkg::MIN_LEN) n_bytes++;

      if (last) begin
        r.device_uid = '0;
        if (n_bytes < rdm_disc_pkg::MIN_LEN) begin
          r.status = rdm_disc_pkg::ST_EMPTY;
        end else if (!sep_found || sep_early || body_cnt < rdm_disc_pkg::BODY_LEN ||
                     nib_bad || sum_acc != rx_sum) begin
          r.status = rdm_disc_pkg::ST_COLLISION;
        end else begin
          r.status     = rdm_disc_pkg::ST_SINGLE;
          r.device_uid = uid_acc;
        end
        outcome_q.push_back(r);
        clear_frame();
      end
    endfunction

    // Called for every result transfer on the output channel.
    task check_result(logic [1:0] st, logic [47:0] uid);
      rdm_disc_pkg::result_t e;
      if (outcome_q.size() == 0) begin
        report($sformatf("result with none owed: status=%0d uid=%h", st, uid));
        return;
      end
      e = outcome_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, wanted %s", st, e.status.name()));
      if (uid !== e.device_uid)
        report($sformatf("device_uid %h, wanted %h", uid, e.device_uid));
    endtask

    task check_drained();
      if (outcome_q.size() != 0)
        report($sformatf("%0d outcomes never arrived", outcome_q.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   sent_bytes;
  int   results_seen;
  logic [7:0] frame_bytes[$];

  disc_frame_scoreboard sb = new();

  rdm_disc_in_if  in_if();
  rdm_disc_out_if out_if();

  rdm_discovery_response_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Any byte but the separator.
  function automatic logic [7:0] lead_byte();
    logic [7:0] d = 8'($urandom);
    if (d == rdm_disc_pkg::SEP_BYTE) d = 8'hFE;
    return d;
  endfunction

  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 2) == 0) return rdm_disc_pkg::SEP_BYTE;
    return 8'($urandom);
  endfunction

  // Appends separator, encoded UID and checksum (optionally corrupted).
  function automatic void add_body(logic [47:0] uid, logic [15:0] sum_flip);
    logic [7:0]  u;
    logic [15:0] csum;
    csum = '0;
    frame_bytes.push_back(rdm_disc_pkg::SEP_BYTE);
    for (int i = 5; i >= 0; i--) begin
      u = uid[i*8 +: 8];
      frame_bytes.push_back({rdm_disc_pkg::MARK_NIB, u[7:4]});
      frame_bytes.push_back({rdm_disc_pkg::MARK_NIB, u[3:0]});
      csum = csum + {8'h00, u} + rdm_disc_pkg::SUM_BIAS;
    end
    csum = csum ^ sum_flip;
    frame_bytes.push_back(csum[15:8]);
    frame_bytes.push_back(csum[7:0]);
  endfunction

  function automatic void build_random_frame(frame_kind_t kind);
    logic [47:0] uid;
    logic [15:0] flip;
    int          pos;
    int          sel;
    frame_bytes.delete();
    sel = $urandom_range(0, 9);
    if (sel == 0)      uid = '0;
    else if (sel == 1) uid = '1;
    else               uid = {16'($urandom), 32'($urandom)};

    case (kind)
      FK_SHORT: begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(tail_byte());
      end
      FK_NOISE: begin
        repeat ($urandom_range(4, 30)) frame_bytes.push_back(tail_byte());
      end
      FK_NO_SEP: begin
        repeat ($urandom_range(4, 24)) frame_bytes.push_back(lead_byte());
      end
      default: begin
        if (kind == FK_EARLY_SEP) repeat ($urandom_range(0, 1)) frame_bytes.push_back(lead_byte());
        else repeat ($urandom_range(2, 8)) frame_bytes.push_back(lead_byte());
        flip = (kind == FK_BAD_SUM) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        add_body(uid, flip);
        // A separator value in the checksum must be taken as data.
        if (kind == FK_BAD_SUM && $urandom_range(0, 2) == 0)
          frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] = rdm_disc_pkg::SEP_BYTE;
        if (kind == FK_BAD_NIBBLE) begin
          pos = frame_bytes.size() - 14 + $urandom_range(0, 11);
          if ($urandom_range(0, 3) == 0) frame_bytes[pos] = rdm_disc_pkg::SEP_BYTE;
          else frame_bytes[pos] = {4'($urandom_range(0, 14)), frame_bytes[pos][3:0]};
        end
        if (kind == FK_CUT_BODY) begin
          repeat ($urandom_range(1, 14)) void'(frame_bytes.pop_back());
        end else begin
          repeat ($urandom_range(0, 3)) frame_bytes.push_back(tail_byte());
        end
      end
    endcase
  endfunction

  // Offers one byte at a falling edge and returns at the falling edge after
  // its transfer, plus the requested gap.
  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= b;
    in_if.frame_end <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    sent_bytes++;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_frame(input bit rush);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, rush ? 0 : gap_len());
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.status, out_if.device_uid);
      results_seen++;
    end
  end

  // Receiver: random stalls, eager stretches and two long hold-offs.
  initial begin
    int stall_left;
    int eager_left;
    int holds_done;
    out_if.ready = 1'b0;
    results_seen = 0;
    stall_left   = 0;
    eager_left   = 0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if ((holds_done == 0 && results_seen >= 6) || (holds_done == 1 && results_seen >= 45)) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (eager_left > 0) begin
          eager_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          eager_left = $urandom_range(30, 120);
        end else begin
          stall_left = gap_len();
        end
      end
    end
  end

  // Sender and run control.
  initial begin
    int          frames;
    int          r;
    frame_kind_t kind;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    rst_n           = 1'b0;
    sent_bytes      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one-byte frame that is only a separator.
    frame_bytes.delete();
    frame_bytes.push_back(rdm_disc_pkg::SEP_BYTE);
    send_frame(1'b1);
    // Three bytes with a valid-looking separator position is still empty.
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(rdm_disc_pkg::SEP_BYTE);
    send_frame(1'b0);
    // Four bytes without any separator.
    frame_bytes.delete();
    frame_bytes.push_back(8'h12);
    frame_bytes.push_back(8'h34);
    frame_bytes.push_back(8'h56);
    frame_bytes.push_back(8'h78);
    send_frame(1'b0);
    // Minimal good frame with an all-ones UID and a trailing separator.
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    add_body(48'hFFFF_FFFF_FFFF, 16'h0000);
    frame_bytes.push_back(rdm_disc_pkg::SEP_BYTE);
    send_frame(1'b1);

    // Random frames, half of them well formed.
    frames = 0;
    while (sent_bytes < BYTE_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 50)      kind = FK_GOOD;
      else if (r < 58) kind = FK_BAD_NIBBLE;
      else if (r < 66) kind = FK_BAD_SUM;
      else if (r < 72) kind = FK_EARLY_SEP;
      else if (r < 80) kind = FK_CUT_BODY;
      else if (r < 86) kind = FK_NO_SEP;
      else if (r < 93) kind = FK_SHORT;
      else             kind = FK_NOISE;
      build_random_frame(kind);
      send_frame($urandom_range(0, 4) == 0);
      frames++;
      // Once, let the decoder drain completely before going on.
      if (frames == 40) begin
        in_if.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
    end

    // Drain and finish.
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ rdm_discovery_response_decoder_core.f @@
rtl/rdm_disc_pkg.sv
rtl/rdm_disc_in_if.sv
rtl/rdm_disc_out_if.sv
rtl/rdm_disc_parse.sv
rtl/rdm_discovery_response_decoder_core.sv
sim/tb.sv
